FILE: hdl/ppm_frame_slot_sequencer_defines.svh
// ---------------------------------------------------------------------------
// PPM frame slot sequencer: assertion macros
// Shared helpers for the concurrent checks of the sequencer.
// ---------------------------------------------------------------------------
`ifndef PPM_FRAME_SLOT_SEQUENCER_DEFINES_SVH
`define PPM_FRAME_SLOT_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PFSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfss check failed");

// next-cycle implication, disabled during reset
`define PFSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfss check failed");

`endif

FILE: hdl/pfss_pkg.sv
// ---------------------------------------------------------------------------
// PPM frame slot sequencer package
// Payload types, control struct and fixed codes.
// ---------------------------------------------------------------------------
package pfss_pkg;

   localparam int LEN_W = 16;

   // func codes
   localparam logic FUNC_PERIOD_END   = 1'b0;
   localparam logic FUNC_WRITE_LENGTH = 1'b1;

   // register indexes
   localparam logic CSR_FRAME_LENGTH     = 1'b0;
   localparam logic CSR_SEPARATOR_LENGTH = 1'b1;

   localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET     = 16'd45000;
   localparam logic [LEN_W-1:0] SEPARATOR_LENGTH_RESET = 16'd600;

   typedef struct packed {
      logic             func;
      logic [2:0]       channel_index;
      logic [LEN_W-1:0] channel_length;
   } req_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0] period_length;
      logic [LEN_W-1:0] pulse_compare;
      logic [3:0]       slot_number;
      logic             is_sync;
   } rsp_payload_type;

   typedef struct packed {
      logic             reg_index;
      logic [LEN_W-1:0] reg_data;
   } csr_payload_type;

   typedef struct packed {
      logic write;   // store one pending length
      logic copy;    // pending bank into active bank
   } bank_ctrl_type;

endpackage

FILE: hdl/pfss_stream_if.sv
// ---------------------------------------------------------------------------
// PPM frame slot sequencer stream interface
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface pfss_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/ppm_frame_slot_sequencer.sv
// ---------------------------------------------------------------------------
// PPM frame slot sequencer
// Path: a req transaction is captured in the input register; a period-end
// result is then loaded into the result register, which drives rsp.
// Throughput: one transaction per cycle; a period-end transaction waits only
// while an unaccepted result holds the result register. Writes give no result.
// Reset: synchronous, clears banks, slot count, frame sum, restores registers.
// ---------------------------------------------------------------------------
module ppm_frame_slot_sequencer #(
   parameter int CHANNELS = 8
) (
   input  logic                clock,
   input  logic                reset,
   pfss_stream_if.sink         req_if,
   pfss_stream_if.source       rsp_if,
   pfss_stream_if.sink         csr_if
);
   import pfss_pkg::*;

`include "ppm_frame_slot_sequencer_defines.svh"

   // counter must also hold CHANNELS itself (the sync slot)
   localparam int CW = $clog2(CHANNELS + 1);
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration
   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [LEN_W-1:0] separator_ff, separator_in;

   // input register
   logic            req_valid_ff, req_valid_in;
   req_payload_type req_data_ff, req_data_in;

   // sequencing state
   logic [CW-1:0]    slot_counter_ff, slot_counter_in;
   logic [LEN_W-1:0] frame_used_ff, frame_used_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic             can_load;
   logic             step;
   logic             slot_event;
   logic             at_sync;
   logic [LEN_W-1:0] chan_len;
   logic [LEN_W-1:0] chan_period;
   logic [LEN_W-1:0] sync_period;
   logic [LEN_W-1:0] sync_compare;
   bank_ctrl_type    bank_ctrl;

   // --- csr port: always ready; user must write only while idle, unenforced
   assign csr_if.ready = 1'b1;

   always_comb begin
      frame_length_in = frame_length_ff;
      separator_in    = separator_ff;
      if (csr_if.valid) begin
         case (csr_if.payload.reg_index)
            CSR_FRAME_LENGTH:     frame_length_in = csr_if.payload.reg_data;
            CSR_SEPARATOR_LENGTH: separator_in    = csr_if.payload.reg_data;
            default: ;
         endcase
      end
   end

   // --- handshake
   // Result register is free when empty or being drained this cycle.
   // Writes never need it, so they retire regardless of rsp back-pressure.
   assign can_load     = !rsp_valid_ff || rsp_if.ready;
   assign step         = req_valid_ff &&
                         ((req_data_ff.func == FUNC_WRITE_LENGTH) || can_load);
   assign req_if.ready = !req_valid_ff || step;
   assign slot_event   = step && (req_data_ff.func == FUNC_PERIOD_END);
   assign at_sync      = (slot_counter_ff == CW'(CHANNELS));

   // --- bank control
   always_comb begin
      bank_ctrl.write = step && (req_data_ff.func == FUNC_WRITE_LENGTH) &&
                        (int'(req_data_ff.channel_index) < CHANNELS);
      bank_ctrl.copy  = slot_event && at_sync;
   end

   pfss_length_bank #(
      .CHANNELS (CHANNELS),
      .IW       (IW)
   ) u_bank (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (bank_ctrl),
      .wr_index (IW'(req_data_ff.channel_index)),
      .wr_data  (req_data_ff.channel_length),
      .rd_index (slot_counter_ff[IW-1:0]),
      .rd_data  (chan_len)
   );

   // --- slot arithmetic, all modulo 2^16
   assign chan_period  = chan_len + separator_ff;
   assign sync_period  = frame_length_ff - frame_used_ff;
   assign sync_compare = sync_period - separator_ff;

   always_comb begin
      req_valid_in    = req_valid_ff;
      req_data_in     = req_data_ff;
      slot_counter_in = slot_counter_ff;
      frame_used_in   = frame_used_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_if.ready) begin
         req_valid_in = req_if.valid;
         req_data_in  = req_if.payload;
      end

      if (slot_event) begin
         rsp_valid_in = 1'b1;
         if (at_sync) begin
            // sync slot fills the rest of the frame, then a new frame starts
            rsp_data_in.period_length = sync_period;
            rsp_data_in.pulse_compare = sync_compare;
            rsp_data_in.slot_number   = 4'(CHANNELS);
            rsp_data_in.is_sync       = 1'b1;
            slot_counter_in           = '0;
            frame_used_in             = '0;
         end else begin
            rsp_data_in.period_length = chan_period;
            rsp_data_in.pulse_compare = chan_len;
            rsp_data_in.slot_number   = 4'(slot_counter_ff);
            rsp_data_in.is_sync       = 1'b0;
            slot_counter_in           = slot_counter_ff + CW'(1);
            frame_used_in             = frame_used_ff + chan_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_RESET;
         separator_ff    <= SEPARATOR_LENGTH_RESET;
         req_valid_ff    <= 1'b0;
         slot_counter_ff <= '0;
         frame_used_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_length_ff <= frame_length_in;
         separator_ff    <= separator_in;
         req_valid_ff    <= req_valid_in;
         slot_counter_ff <= slot_counter_in;
         frame_used_ff   <= frame_used_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // --- checks
   `PFSS_ASSERT_NOW(a_counter_range, clock, reset, 1'b1,
                    slot_counter_ff <= CW'(CHANNELS))
   `PFSS_ASSERT_NEXT(a_sync_restarts, clock, reset, slot_event && at_sync,
                     (slot_counter_ff == '0) && (frame_used_ff == '0))
   `PFSS_ASSERT_NOW(a_chan_period, clock, reset, rsp_valid_ff && !rsp_data_ff.is_sync,
                    rsp_data_ff.period_length ==
                    LEN_W'(rsp_data_ff.pulse_compare + separator_ff))
   `PFSS_ASSERT_NOW(a_sync_compare, clock, reset, rsp_valid_ff && rsp_data_ff.is_sync,
                    rsp_data_ff.pulse_compare ==
                    LEN_W'(rsp_data_ff.period_length - separator_ff))

endmodule

FILE: hdl/pfss_length_bank.sv
// ---------------------------------------------------------------------------
// PPM length banks
// Pending bank written per channel, active bank loaded at frame end.
// ---------------------------------------------------------------------------
module pfss_length_bank #(
   parameter int CHANNELS = 8,
   parameter int IW       = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pfss_pkg::bank_ctrl_type ctrl,
   input  logic [IW-1:0]           wr_index,
   input  logic [15:0]             wr_data,
   input  logic [IW-1:0]           rd_index,
   output logic [15:0]             rd_data
);
   import pfss_pkg::*;

   logic [LEN_W-1:0] pending_ff [CHANNELS];
   logic [LEN_W-1:0] active_ff  [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pending_ff[i] <= '0;
            active_ff[i]  <= '0;
         end
      end else begin
         if (ctrl.write) begin
            pending_ff[wr_index] <= wr_data;
         end
         if (ctrl.copy) begin
            active_ff <= pending_ff;
         end
      end
   end

   assign rd_data = active_ff[rd_index];

endmodule
